>>> rtl/qte_pkg.sv
// ============================================================================
// qte_pkg
// Shared widths, constants, types and the arctangent table for the
// quaternion to Euler angle converter.
// ============================================================================
package qte_pkg;

	localparam int QW           = 16;              // quaternion component width
	localparam int PRODW        = 2 * QW;          // one product of two components
	localparam int PW           = 34;              // sine and cosine terms, Q6.28
	localparam int XW           = 37;              // CORDIC vector datapath
	localparam int ZW           = 28;              // CORDIC angle accumulator, Q24
	localparam int ANG_W        = 16;              // roll and yaw
	localparam int PITCH_W      = 15;              // pitch
	localparam int CORDIC_ITERATIONS = 16;
	localparam int CLAT         = CORDIC_ITERATIONS + 2;
	localparam int SQ_STEPS     = 29;              // one root bit per stage
	localparam int ROOT_W       = SQ_STEPS;
	localparam int RAD_W        = 2 * SQ_STEPS;    // radicand, padded to an even width
	localparam int REM_W        = ROOT_W + 2;
	localparam int SINP_W       = 29;              // unclamped sine of pitch
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int FRAC_DROP    = 11;              // Q24 to Q13

	localparam logic signed [PW-1:0]  ONE_Q28     = 34'sd268435456;
	localparam logic signed [PW-1:0]  NEG_ONE_Q28 = -34'sd268435456;
	localparam logic [RAD_W-1:0]      ONE_Q56     = 58'd1 << 56;
	localparam logic signed [ZW-1:0]  HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [ZW-1:0]  ROUND_HALF  = 28'sd1024;
	localparam logic signed [ZW-1:0]  PI_Q13      = 28'sd25736;
	localparam logic signed [ZW-1:0]  HALF_PI_Q13 = 28'sd12868;

	// Terms handed from the front part to the back part.
	typedef struct packed {
		logic signed [PW-1:0] sinr;
		logic signed [PW-1:0] cosr;
		logic signed [PW-1:0] sinp;
		logic signed [PW-1:0] siny;
		logic signed [PW-1:0] cosy;
		logic                 clamp;
	} qte_terms_t;

	// atan(2^-i) in radians, Q24.
	function automatic logic signed [ZW-1:0] atan_q24(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0:  r = 28'sd13176795;
			1:  r = 28'sd7778716;
			2:  r = 28'sd4110060;
			3:  r = 28'sd2086331;
			4:  r = 28'sd1047214;
			5:  r = 28'sd524117;
			6:  r = 28'sd262123;
			7:  r = 28'sd131069;
			8:  r = 28'sd65536;
			9:  r = 28'sd32768;
			10: r = 28'sd16384;
			11: r = 28'sd8192;
			12: r = 28'sd4096;
			13: r = 28'sd2048;
			14: r = 28'sd1024;
			15: r = 28'sd512;
			16: r = 28'sd256;
			17: r = 28'sd128;
			18: r = 28'sd64;
			19: r = 28'sd32;
			20: r = 28'sd16;
			21: r = 28'sd8;
			22: r = 28'sd4;
			23: r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/qte_if.sv
// ============================================================================
// qte_in_if / qte_out_if
// Valid/ready channels carrying one quaternion word and one angle word.
// ============================================================================
interface qte_in_if;
	import qte_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] quat_w;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
	import qte_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [ANG_W-1:0]   roll_angle;
	logic signed [PITCH_W-1:0] pitch_angle;
	logic signed [ANG_W-1:0]   yaw_angle;
	logic                      pitch_clamped;
	modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		input ready);
	modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		output ready);
endinterface

>>> rtl/quaternion_to_euler_angles_top.sv
// Throughput: one word per cycle unless the sink stalls; the products, the square
// root (one root bit per stage) and the three CORDICs (one iteration per stage)
// are fully pipelined.
// Reset: arst_n clears all valid bits and queue pointers at once; no clearing pass.
// ============================================================================
// quaternion_to_euler_angles_top
// Converts a Q1.14 quaternion into ZYX roll and yaw in Q3.13 and pitch in Q2.13 radians.
// ============================================================================
module quaternion_to_euler_angles_top import qte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	qte_in_if.sink    quat,
	qte_out_if.source euler
);

	// The front part forms the three sine and two cosine terms in two stages and
	// marks a pitch sine of magnitude one or more. Its words wait in a four-entry
	// queue, so the front takes words while the sink holds the back until the queue fills.
	qte_terms_t f_terms, b_terms;
	logic       push, pop, full, empty;

	qte_front u_front (
		.clk(clk), .arst_n(arst_n), .quat(quat), .full(full), .push(push), .terms(f_terms)
	);

	qte_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(f_terms), .full(full),
		.pop(pop), .rdata(b_terms), .empty(empty)
	);

	// The back part squares the pitch sine, takes the root of one minus that square
	// for the pitch cosine, then runs roll, pitch and yaw through their own CORDICs.
	// Its whole pipeline advances whenever the output register is free or taken.
	qte_back u_back (
		.clk(clk), .arst_n(arst_n), .rdata(b_terms), .empty(empty), .pop(pop), .euler(euler)
	);

	// The queue is never written when full, nor read when empty.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");

	// A clamped pitch always carries the quarter turn.
	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		(euler.valid && euler.pitch_clamped) |->
		(euler.pitch_angle == 15'sd12868 || euler.pitch_angle == -15'sd12868))
		else $error("clamped pitch not at a quarter turn");

	// Roll and yaw stay within a half turn after saturation.
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid |-> (euler.roll_angle <= 16'sd25736 && euler.roll_angle >= -16'sd25736
		&& euler.yaw_angle <= 16'sd25736 && euler.yaw_angle >= -16'sd25736))
		else $error("roll or yaw out of range");

endmodule

>>> rtl/qte_front.sv
// ============================================================================
// qte_front
// Accepts quaternion words, forms the sine and cosine terms and flags a
// pitch sine that reaches magnitude one.
// ============================================================================
module qte_front import qte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	qte_in_if.sink      quat,
	input  logic        full,
	output logic        push,
	output qte_terms_t  terms
);

	logic                    en;
	logic                    v_s1, v_s2;
	logic signed [PRODW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	qte_terms_t              t_s2;
	logic signed [PW-1:0]    sinp_d;

	assign en         = !v_s2 || !full;
	assign quat.ready = en;
	assign push       = v_s2 && !full;
	assign terms      = t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= quat.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat.quat_w * quat.quat_x;
			yz_s1 <= quat.quat_y * quat.quat_z;
			xx_s1 <= quat.quat_x * quat.quat_x;
			yy_s1 <= quat.quat_y * quat.quat_y;
			wy_s1 <= quat.quat_w * quat.quat_y;
			zx_s1 <= quat.quat_z * quat.quat_x;
			wz_s1 <= quat.quat_w * quat.quat_z;
			xy_s1 <= quat.quat_x * quat.quat_y;
			zz_s1 <= quat.quat_z * quat.quat_z;
		end
	end

	assign sinp_d = (PW'(wy_s1) - PW'(zx_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2.sinr  <= (PW'(wx_s1) + PW'(yz_s1)) <<< 1;
			t_s2.cosr  <= ONE_Q28 - ((PW'(xx_s1) + PW'(yy_s1)) <<< 1);
			t_s2.sinp  <= sinp_d;
			t_s2.siny  <= (PW'(wz_s1) + PW'(xy_s1)) <<< 1;
			t_s2.cosy  <= ONE_Q28 - ((PW'(yy_s1) + PW'(zz_s1)) <<< 1);
			t_s2.clamp <= (sinp_d >= ONE_Q28) || (sinp_d <= NEG_ONE_Q28);
		end
	end

endmodule

>>> rtl/qte_fifo.sv
// ============================================================================
// qte_fifo
// Short queue of term words between the front and back parts.
// ============================================================================
module qte_fifo import qte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qte_terms_t wdata,
	output logic       full,
	input  logic       pop,
	output qte_terms_t rdata,
	output logic       empty
);

	qte_terms_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/qte_cordic.sv
// ============================================================================
// qte_cordic
// Pipelined vectoring CORDIC giving a saturated atan2 in Q13.
// ============================================================================
module qte_cordic import qte_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic                    narrow,
	input  logic signed [PW-1:0]    y_in,
	input  logic signed [PW-1:0]    x_in,
	output logic signed [ANG_W-1:0] angle
);

	logic signed [XW-1:0] x_q [CORDIC_ITERATIONS+1];
	logic signed [XW-1:0] y_q [CORDIC_ITERATIONS+1];
	logic signed [ZW-1:0] z_q [CORDIC_ITERATIONS+1];
	logic                 zero_q [CORDIC_ITERATIONS+1];
	logic                 nar_q  [CORDIC_ITERATIONS+1];
	logic signed [XW-1:0] xe, ye, xp, yp;
	logic signed [ZW-1:0] zp, zr, lim;
	logic signed [ANG_W-1:0] ang_q;

	assign xe = XW'(x_in);
	assign ye = XW'(y_in);

	// A vector in the left half plane is first turned by a quarter turn.
	always_comb begin
		xp = xe;
		yp = ye;
		zp = '0;
		if (xe < 0) begin
			if (ye >= 0) begin
				xp = ye;
				yp = -xe;
				zp = HALF_PI_Q24;
			end else begin
				xp = -ye;
				yp = xe;
				zp = -HALF_PI_Q24;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= xp;
			y_q[0]    <= yp;
			z_q[0]    <= zp;
			zero_q[0] <= (x_in == '0) && (y_in == '0);
			nar_q[0]  <= narrow;
			for (int k = 0; k < CORDIC_ITERATIONS; k++) begin
				if (!y_q[k][XW-1]) begin
					x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] + atan_q24(k);
				end else begin
					x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] - atan_q24(k);
				end
				zero_q[k+1] <= zero_q[k];
				nar_q[k+1]  <= nar_q[k];
			end
		end
	end

	assign zr  = (z_q[CORDIC_ITERATIONS] + ROUND_HALF) >>> FRAC_DROP;
	assign lim = nar_q[CORDIC_ITERATIONS] ? HALF_PI_Q13 : PI_Q13;

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (zero_q[CORDIC_ITERATIONS]) begin
				ang_q <= '0;
			end else if (zr > lim) begin
				ang_q <= ANG_W'(lim);
			end else if (zr < -lim) begin
				ang_q <= ANG_W'(-lim);
			end else begin
				ang_q <= ANG_W'(zr);
			end
		end
	end

	assign angle = ang_q;

endmodule

>>> rtl/qte_back.sv
// ============================================================================
// qte_back
// Takes term words from the queue, finds the pitch cosine by a pipelined
// square root and runs the three angle CORDICs into the output register.
// ============================================================================
module qte_back import qte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qte_terms_t  rdata,
	input  logic        empty,
	output logic        pop,
	qte_out_if.source   euler
);

	logic                     en;
	logic                     v_s1, v_s2, v_s3;
	qte_terms_t               t_s1, t_s2, t_s3;
	logic signed [SINP_W-1:0] sp;
	logic [RAD_W-1:0]         sq_s2, rad_s3;

	logic                     rv_q   [SQ_STEPS];
	qte_terms_t               rt_q   [SQ_STEPS];
	logic [REM_W-1:0]         rem_q  [SQ_STEPS];
	logic [ROOT_W-1:0]        root_q [SQ_STEPS];
	logic [RAD_W-1:0]         rad_q  [SQ_STEPS];
	logic [REM_W-1:0]         rem_d  [SQ_STEPS];
	logic [ROOT_W-1:0]        root_d [SQ_STEPS];
	logic [RAD_W-1:0]         rad_d  [SQ_STEPS];

	logic                     cv_q [CLAT];
	logic                     cc_q [CLAT];
	logic                     cs_q [CLAT];
	qte_terms_t               tl;
	logic signed [PW-1:0]     py, px;
	logic signed [ANG_W-1:0]  roll_a, yaw_a, pitch_a;

	logic                      ov_q;
	logic signed [ANG_W-1:0]   roll_q, yaw_q;
	logic signed [PITCH_W-1:0] pitch_q;
	logic                      clamp_q;

	assign en  = !ov_q || euler.ready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				rv_q[k] <= 1'b0;
			end
			for (int k = 0; k < CLAT; k++) begin
				cv_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			rv_q[0] <= v_s3;
			for (int k = 1; k < SQ_STEPS; k++) begin
				rv_q[k] <= rv_q[k-1];
			end
			cv_q[0] <= rv_q[SQ_STEPS-1];
			for (int k = 1; k < CLAT; k++) begin
				cv_q[k] <= cv_q[k-1];
			end
			ov_q <= cv_q[CLAT-1];
		end
	end

	// Square of the pitch sine; a clamped sine is squared as zero and only its sign is used further.
	assign sp = t_s1.clamp ? '0 : t_s1.sinp[SINP_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= rdata;
			t_s2   <= t_s1;
			sq_s2  <= RAD_W'(sp * sp);
			t_s3   <= t_s2;
			rad_s3 <= ONE_Q56 - sq_s2;
		end
	end

	// Digit-by-digit square root, one root bit per stage.
	always_comb begin
		logic [REM_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		logic [RAD_W-1:0]  rad_i;
		logic [REM_W+1:0]  rem2;
		logic [REM_W+1:0]  trial;
		for (int k = 0; k < SQ_STEPS; k++) begin
			if (k == 0) begin
				rem_i  = '0;
				root_i = '0;
				rad_i  = rad_s3;
			end else begin
				rem_i  = rem_q[k-1];
				root_i = root_q[k-1];
				rad_i  = rad_q[k-1];
			end
			rem2  = {rem_i, rad_i[RAD_W-1 -: 2]};
			trial = (REM_W+2)'({root_i, 2'b01});
			if (rem2 >= trial) begin
				rem_d[k]  = REM_W'(rem2 - trial);
				root_d[k] = {root_i[ROOT_W-2:0], 1'b1};
			end else begin
				rem_d[k]  = REM_W'(rem2);
				root_d[k] = {root_i[ROOT_W-2:0], 1'b0};
			end
			rad_d[k] = rad_i << 2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_STEPS; k++) begin
				rem_q[k]  <= rem_d[k];
				root_q[k] <= root_d[k];
				rad_q[k]  <= rad_d[k];
				rt_q[k]   <= (k == 0) ? t_s3 : rt_q[k-1];
			end
		end
	end

	assign tl = rt_q[SQ_STEPS-1];
	assign py = tl.clamp ? '0 : tl.sinp;
	assign px = tl.clamp ? '0 : PW'(root_q[SQ_STEPS-1]);

	qte_cordic u_roll (
		.clk(clk), .en(en), .narrow(1'b0), .y_in(tl.sinr), .x_in(tl.cosr), .angle(roll_a)
	);
	qte_cordic u_yaw (
		.clk(clk), .en(en), .narrow(1'b0), .y_in(tl.siny), .x_in(tl.cosy), .angle(yaw_a)
	);
	qte_cordic u_pitch (
		.clk(clk), .en(en), .narrow(1'b1), .y_in(py), .x_in(px), .angle(pitch_a)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cc_q[0] <= tl.clamp;
			cs_q[0] <= tl.sinp[PW-1];
			for (int k = 1; k < CLAT; k++) begin
				cc_q[k] <= cc_q[k-1];
				cs_q[k] <= cs_q[k-1];
			end
			roll_q  <= roll_a;
			yaw_q   <= yaw_a;
			clamp_q <= cc_q[CLAT-1];
			if (cc_q[CLAT-1]) begin
				pitch_q <= cs_q[CLAT-1] ? -PITCH_W'(HALF_PI_Q13) : PITCH_W'(HALF_PI_Q13);
			end else begin
				pitch_q <= PITCH_W'(pitch_a);
			end
		end
	end

	assign euler.valid         = ov_q;
	assign euler.roll_angle    = roll_q;
	assign euler.pitch_angle   = pitch_q;
	assign euler.yaw_angle     = yaw_q;
	assign euler.pitch_clamped = clamp_q;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Quaternion to Euler angle converter testbench
// Drives quaternion words with random gaps, takes angle words under random
// back-pressure, and compares every angle word with a bit-exact predictor.
// ============================================================================

// Holds the angles predicted for accepted quaternions, in order of arrival.
class euler_scoreboard;
	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic               clamped;
	} angles_t;

	angles_t pending[$];
	int      errors;

	// Floor shift right of a signed value.
	static function longint asr(longint v, int s);
		return v >>> s;
	endfunction

	static function longint int_sqrt(longint v);
		longint res, bitv;
		res  = 0;
		bitv = 64'sd1 <<< 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	static function longint atan_step(int i);
		longint tbl[24];
		tbl = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
			131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
			128, 64, 32, 16, 8, 4, 2};
		return tbl[i];
	endfunction

	// Vectoring arctangent, result in Q13 and saturated to +-lim.
	static function longint vector_angle(longint y, longint x, longint lim);
		longint acc, t, dx, dy;
		acc = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; acc = 26353589;
			end else begin
				x = -y; y = t; acc = -26353589;
			end
		end
		for (int i = 0; i < qte_pkg::CORDIC_ITERATIONS && i < 24; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (y >= 0) begin
				x = x + dx; y = y - dy; acc = acc + atan_step(i);
			end else begin
				x = x - dx; y = y + dy; acc = acc - atan_step(i);
			end
		end
		acc = asr(acc + 1024, 11);
		if (acc > lim) acc = lim;
		if (acc < -lim) acc = -lim;
		return acc;
	endfunction

	function void note_quaternion(logic signed [15:0] qw, logic signed [15:0] qx,
		logic signed [15:0] qy, logic signed [15:0] qz);
		longint w, x, y, z, sinr, cosr, sinp, siny, cosy, one, p;
		angles_t a;
		w = qw; x = qx; y = qy; z = qz;
		one  = 64'sd1 <<< 28;
		sinr = 2 * (w * x + y * z);
		cosr = one - 2 * (x * x + y * y);
		sinp = 2 * (w * y - z * x);
		siny = 2 * (w * z + x * y);
		cosy = one - 2 * (y * y + z * z);
		a.roll = 16'(vector_angle(sinr, cosr, 25736));
		a.yaw  = 16'(vector_angle(siny, cosy, 25736));
		if (sinp >= one || sinp <= -one) begin
			a.clamped = 1'b1;
			p = (sinp > 0) ? 12868 : -12868;
		end else begin
			a.clamped = 1'b0;
			p = vector_angle(sinp, int_sqrt((64'sd1 <<< 56) - sinp * sinp), 12868);
		end
		a.pitch = 15'(p);
		pending.push_back(a);
	endfunction

	function void check_angles(logic signed [15:0] roll, logic signed [14:0] pitch,
		logic signed [15:0] yaw, logic clamped);
		angles_t e;
		if (pending.size() == 0) begin
			$error("angle word arrived with none expected");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (roll !== e.roll) begin
			$error("roll_angle: expected %0d, got %0d", e.roll, roll);
			errors++;
		end
		if (pitch !== e.pitch) begin
			$error("pitch_angle: expected %0d, got %0d", e.pitch, pitch);
			errors++;
		end
		if (yaw !== e.yaw) begin
			$error("yaw_angle: expected %0d, got %0d", e.yaw, yaw);
			errors++;
		end
		if (clamped !== e.clamped) begin
			$error("pitch_clamped: expected %0d, got %0d", e.clamped, clamped);
			errors++;
		end
	endfunction
endclass

module tb;
	import qte_pkg::*;

	localparam int N_RANDOM = 1600;
	// Pipeline latency with a margin, used for the drain at the end.
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qte_in_if  quat();
	qte_out_if euler();

	euler_scoreboard angle_board = new();

	// Set once every quaternion word has been handed over.
	bit all_sent = 1'b0;
	// Zero means the receiver never stalls; used for a calm stretch.
	bit stall_on = 1'b1;

	quaternion_to_euler_angles_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.quat  (quat),
		.euler (euler)
	);

	always #1 clk = ~clk;

	// Presents one quaternion word and holds it until it is taken. The gap before
	// it is drawn here; valid stays high across back-to-back words.
	task automatic send_quaternion(logic signed [15:0] w, logic signed [15:0] x,
		logic signed [15:0] y, logic signed [15:0] z, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			quat.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		quat.valid  <= 1'b1;
		quat.quat_w <= w;
		quat.quat_x <= x;
		quat.quat_y <= y;
		quat.quat_z <= z;
		do
			@(posedge clk);
		while (!quat.ready);
		angle_board.note_quaternion(w, x, y, z);
		@(negedge clk);
	endtask

	// A component: mostly within the unit range, sometimes any 16-bit pattern.
	function automatic logic signed [15:0] rand_component();
		case ($urandom_range(0, 9))
			0:       return 16'($urandom);
			1:       return ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384);
			default: return 16'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// Stimulus: directed corners first, then random words.
	initial begin
		logic signed [15:0] w, x, y, z;
		real a, b, c, d, n;
		quat.valid  = 1'b0;
		quat.quat_w = '0;
		quat.quat_x = '0;
		quat.quat_y = '0;
		quat.quat_z = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Identity, all zero (every sine term zero), and the extremes.
		send_quaternion(16'sd16384, 0, 0, 0, 0);
		send_quaternion(0, 0, 0, 0, 0);
		send_quaternion(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0);
		send_quaternion(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0);
		send_quaternion(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 0);
		// Pitch near plus and minus half pi, at zero, and clamped (gimbal lock).
		send_quaternion(16'sd11585, 0, 16'sd11585, 0, 0);
		send_quaternion(16'sd11585, 0, -16'sd11585, 0, 0);
		send_quaternion(16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585, 0);
		send_quaternion(16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192, 0);
		// Half turns about each axis: negative cosine terms, with the sine
		// term at zero, just above and just below.
		send_quaternion(0, 16'sd16384, 0, 0, 1);
		send_quaternion(0, 0, 0, 16'sd16384, 1);
		send_quaternion(0, 0, 16'sd16384, 0, 1);
		send_quaternion(16'sd1, 16'sd16384, 0, 0, 1);
		send_quaternion(-16'sd1, 16'sd16384, 0, 0, 1);
		send_quaternion(16'sd1, 0, 0, 16'sd16384, 1);
		send_quaternion(-16'sd1, 0, 0, 16'sd16384, 1);
		// Pitch just short of the clamp on either side, then a word near the negated identity.
		send_quaternion(16'sd11584, 0, 16'sd11585, 0, 1);
		send_quaternion(16'sd11584, 0, -16'sd11585, 0, 1);
		send_quaternion(-16'sd16384, 16'sd1, -16'sd1, 16'sd1, 1);

		// Random part: mostly unit quaternions, the rest raw components.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) stall_on = 1'b0;
			if (i == N_RANDOM / 2 + 200) stall_on = 1'b1;
			if ($urandom_range(0, 3) != 0) begin
				a = real'(int'($urandom_range(0, 2000)) - 1000);
				b = real'(int'($urandom_range(0, 2000)) - 1000);
				c = real'(int'($urandom_range(0, 2000)) - 1000);
				d = real'(int'($urandom_range(0, 2000)) - 1000);
				n = $sqrt(a * a + b * b + c * c + d * d);
				if (n < 1.0) begin
					a = 1.0; n = 1.0;
				end
				w = 16'($rtoi(16384.0 * a / n));
				x = 16'($rtoi(16384.0 * b / n));
				y = 16'($rtoi(16384.0 * c / n));
				z = 16'($rtoi(16384.0 * d / n));
			end else begin
				w = rand_component();
				x = rand_component();
				y = rand_component();
				z = rand_component();
			end
			send_quaternion(w, x, y, z, (i % 400) >= 100);
		end
		quat.valid <= 1'b0;
		all_sent = 1'b1;
	end

	// Receiver: draws a stall for each angle word, then samples at the rising edge.
	initial begin
		int stall;
		euler.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = stall_on ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				euler.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			euler.ready <= 1'b1;
			do
				@(posedge clk);
			while (!euler.valid);
			angle_board.check_angles(euler.roll_angle, euler.pitch_angle,
				euler.yaw_angle, euler.pitch_clamped);
		end
	end

	// End of run: wait until nothing is outstanding, then let the pipeline settle.
	initial begin
		wait (all_sent);
		while (angle_board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (angle_board.errors == 0 && angle_board.pending.size() == 0) begin
			$display("quaternion_to_euler_angles_top test passed");
		end else begin
			$display("quaternion_to_euler_angles_top test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#400000;
		$display("quaternion_to_euler_angles_top test failed");
		$finish;
	end

endmodule
